// File: rtl/pidc_pkg.sv
// Package for the PID controller step block: fixed field widths, reset values,
// register indexes and the mode flag group. No dependencies.
package pidc_pkg;

  // Gains and the sample period are fixed 16-bit unsigned fields.
  localparam int GAIN_W = 16;
  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam int OUT_MAX_RESET = 255;
  localparam logic [TICK_W-1:0] PERIOD_RESET = TICK_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_OUT_MIN      = 3'd3,
    REG_OUT_MAX      = 3'd4,
    REG_P_ON_MEAS    = 3'd5,
    REG_REVERSE      = 3'd6,
    REG_SAMPLE_PER   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic p_on_meas;
    logic reverse;
  } mode_t;

endpackage

// File: rtl/pidc_clamp.sv
// Saturating clamp of a signed value to [lo, hi], upper bound tested first.
// Standalone; uses nothing from the package.
module pidc_clamp #(
  parameter int VW = 26,
  parameter int BW = 24
) (
  input  logic signed [VW-1:0] value,
  input  logic signed [BW-1:0] lo,
  input  logic signed [BW-1:0] hi,
  output logic signed [BW-1:0] result
);

  logic signed [VW-1:0] lo_x;
  logic signed [VW-1:0] hi_x;

  assign lo_x = VW'(lo);
  assign hi_x = VW'(hi);

  // With inverted limits the upper test wins, then the lower one.
  always_comb begin
    priority if (value > hi_x) begin
      result = hi;
    end else if (value < lo_x) begin
      result = lo;
    end else begin
      result = BW'(value);
    end
  end

endmodule

// File: rtl/pidc_core.sv
// Combinational PID step for one tick: mode transfer, tick timing, the three
// gain products and the clamps. Depends on pidc_pkg and pidc_clamp.
module pidc_core #(
  parameter int DATA_WIDTH = 16,
  parameter int GAIN_FRAC_BITS = 8,
  localparam int FXW = DATA_WIDTH + GAIN_FRAC_BITS,
  localparam int IW = FXW + 1
) (
  input  logic signed [DATA_WIDTH-1:0]      measured,
  input  logic signed [DATA_WIDTH-1:0]      target,
  input  logic                              auto_mode,
  input  logic signed [DATA_WIDTH-1:0]      manual_output,
  input  logic [pidc_pkg::GAIN_W-1:0]       gain_p,
  input  logic [pidc_pkg::GAIN_W-1:0]       gain_i,
  input  logic [pidc_pkg::GAIN_W-1:0]       gain_d,
  input  logic signed [DATA_WIDTH-1:0]      out_min,
  input  logic signed [DATA_WIDTH-1:0]      out_max,
  input  pidc_pkg::mode_t                   mode,
  input  logic [pidc_pkg::TICK_W-1:0]       sample_period,
  input  logic signed [IW-1:0]              integral_sum,
  input  logic                              clamp_pending,
  input  logic signed [DATA_WIDTH-1:0]      last_measured,
  input  logic [pidc_pkg::TICK_W-1:0]       ticks,
  input  logic                              auto_flag,
  output logic signed [IW-1:0]              integral_hold,
  output logic signed [IW-1:0]              integral_next,
  output logic signed [DATA_WIDTH-1:0]      last_next,
  output logic [pidc_pkg::TICK_W-1:0]       ticks_next,
  output logic                              auto_next,
  output logic signed [DATA_WIDTH-1:0]      drive,
  output logic                              computed
);

  localparam int KW = pidc_pkg::GAIN_W + 1;
  localparam int EW = DATA_WIDTH + 1;
  localparam int PW = KW + EW;
  localparam int SW = PW + 2;

  logic signed [FXW-1:0] lo_fx;
  logic signed [FXW-1:0] hi_fx;
  logic signed [FXW-1:0] manual_fx;
  logic signed [FXW-1:0] preload_fx;
  logic signed [FXW-1:0] held_fx;
  logic signed [IW-1:0]  integral_start;
  logic signed [DATA_WIDTH-1:0] last_start;
  logic [pidc_pkg::TICK_W-1:0] ticks_inc;
  logic                  run;
  logic                  preload;
  logic signed [KW-1:0]  kp;
  logic signed [KW-1:0]  ki;
  logic signed [KW-1:0]  kd;
  logic signed [EW-1:0]  err;
  logic signed [EW-1:0]  din;
  logic signed [EW-1:0]  p_operand;
  logic signed [PW-1:0]  p_prod;
  logic signed [PW-1:0]  i_prod;
  logic signed [PW-1:0]  d_prod;
  logic signed [SW-1:0]  integral_raw;
  logic signed [FXW-1:0] integral_cl;
  logic signed [SW-1:0]  out_raw;
  logic signed [FXW-1:0] out_cl;

  assign lo_fx = FXW'(out_min) <<< GAIN_FRAC_BITS;
  assign hi_fx = FXW'(out_max) <<< GAIN_FRAC_BITS;
  assign manual_fx = FXW'(manual_output) <<< GAIN_FRAC_BITS;

  // A limit write while in auto leaves the accumulator to be clamped again.
  pidc_clamp #(.VW(IW), .BW(FXW)) u_hold_clamp (
    .value(integral_sum), .lo(lo_fx), .hi(hi_fx), .result(held_fx)
  );

  assign integral_hold = clamp_pending ? IW'(held_fx) : integral_sum;

  // Bumpless transfer: entering auto preloads the accumulator and last input.
  pidc_clamp #(.VW(FXW), .BW(FXW)) u_preload_clamp (
    .value(manual_fx), .lo(lo_fx), .hi(hi_fx), .result(preload_fx)
  );

  assign preload = auto_mode && !auto_flag;
  assign integral_start = preload ? IW'(preload_fx) : integral_hold;
  assign last_start = preload ? measured : last_measured;
  assign auto_next = auto_mode;

  assign ticks_inc = (&ticks) ? ticks : ticks + 1'b1;
  assign run = auto_mode && (ticks_inc >= sample_period);

  assign kp = mode.reverse ? -$signed({1'b0, gain_p}) : $signed({1'b0, gain_p});
  assign ki = mode.reverse ? -$signed({1'b0, gain_i}) : $signed({1'b0, gain_i});
  assign kd = mode.reverse ? -$signed({1'b0, gain_d}) : $signed({1'b0, gain_d});

  assign err = EW'(target) - EW'(measured);
  assign din = EW'(measured) - EW'(last_start);

  // The proportional gain acts on either the error or the input change.
  assign p_operand = mode.p_on_meas ? din : err;
  assign p_prod = PW'(kp) * PW'(p_operand);
  assign i_prod = PW'(ki) * PW'(err);
  assign d_prod = PW'(kd) * PW'(din);

  assign integral_raw = SW'(integral_start) + SW'(i_prod)
                      - (mode.p_on_meas ? SW'(p_prod) : SW'(0));

  pidc_clamp #(.VW(SW), .BW(FXW)) u_integral_clamp (
    .value(integral_raw), .lo(lo_fx), .hi(hi_fx), .result(integral_cl)
  );

  assign out_raw = (mode.p_on_meas ? SW'(0) : SW'(p_prod)) + SW'(integral_cl)
                 - SW'(d_prod);

  pidc_clamp #(.VW(SW), .BW(FXW)) u_out_clamp (
    .value(out_raw), .lo(lo_fx), .hi(hi_fx), .result(out_cl)
  );

  always_comb begin
    if (run) begin
      integral_next = IW'(integral_cl);
      last_next     = measured;
      ticks_next    = '0;
      // Dropping the fraction bits of a two's complement value floors it.
      drive         = out_cl[FXW-1:GAIN_FRAC_BITS];
      computed      = 1'b1;
    end else begin
      integral_next = integral_start;
      last_next     = last_start;
      ticks_next    = ticks_inc;
      drive         = manual_output;
      computed      = 1'b0;
    end
  end

endmodule

// File: rtl/pid_controller_step.sv
// Top level of the PID controller step: handshakes, configuration registers,
// controller state and the input and result registers.
// Depends on pidc_pkg and pidc_core (which uses pidc_clamp).
//
//   Channel   Handshake               Carries
//   -------   ---------------------   ----------------------------------------
//   input     in_valid / in_ready     measured, target, auto_mode, manual_output
//   result    out_valid / out_ready   drive, computed, in_auto
//   config    cfg_we (no wait)        cfg_index, cfg_data
//
// Every input transaction is one time tick and yields exactly one result
// transaction. The block sustains one transaction per cycle while the consumer
// takes each result: a tick is caught in the input register, runs through the
// combinational PID step (three gain multipliers and the clamps) and lands in
// the result register, from which the consumer takes it. The controller state
// advances at the edge at which a tick moves from the input register into the
// result register. When the result register is full and not taken, the tick
// waits in the input register and in_ready falls; nothing is dropped.
// Reset clears the handshake state, loads the register reset values and puts
// the controller in manual mode with the tick counter saturated, so the first
// automatic tick computes at once.
module pid_controller_step #(
  parameter int DATA_WIDTH = 16,
  parameter int GAIN_FRAC_BITS = 8,
  localparam int CFG_W = (DATA_WIDTH > pidc_pkg::GAIN_W) ? DATA_WIDTH
                                                          : pidc_pkg::GAIN_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [DATA_WIDTH-1:0]     measured,
  input  logic signed [DATA_WIDTH-1:0]     target,
  input  logic                             auto_mode,
  input  logic signed [DATA_WIDTH-1:0]     manual_output,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [DATA_WIDTH-1:0]     drive,
  output logic                             computed,
  output logic                             in_auto,
  input  logic                             cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]                 cfg_data
);

  localparam int IW = DATA_WIDTH + GAIN_FRAC_BITS + 1;

  // Configuration registers.
  logic [pidc_pkg::GAIN_W-1:0]   gain_p;
  logic [pidc_pkg::GAIN_W-1:0]   gain_i;
  logic [pidc_pkg::GAIN_W-1:0]   gain_d;
  logic signed [DATA_WIDTH-1:0]  out_min;
  logic signed [DATA_WIDTH-1:0]  out_max;
  pidc_pkg::mode_t               mode;
  logic [pidc_pkg::TICK_W-1:0]   sample_period;

  // Controller state.
  logic signed [IW-1:0]          integral_sum;
  logic                          clamp_pending;
  logic signed [DATA_WIDTH-1:0]  last_measured;
  logic [pidc_pkg::TICK_W-1:0]   ticks;
  logic                          auto_flag;

  // Input register.
  logic                          s1_valid;
  logic signed [DATA_WIDTH-1:0]  s1_measured;
  logic signed [DATA_WIDTH-1:0]  s1_target;
  logic                          s1_auto_mode;
  logic signed [DATA_WIDTH-1:0]  s1_manual;

  // Step results.
  logic signed [IW-1:0]          integral_hold;
  logic signed [IW-1:0]          integral_next;
  logic signed [DATA_WIDTH-1:0]  last_next;
  logic [pidc_pkg::TICK_W-1:0]   ticks_next;
  logic                          auto_next;
  logic signed [DATA_WIDTH-1:0]  drive_next;
  logic                          computed_next;

  logic                          advance;
  logic                          limit_write;

  // A tick moves on when the result register is empty or being emptied.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Writing either limit while in auto sets clamp_pending, which re-clamps the accumulator.
  assign limit_write = cfg_we && auto_flag &&
                       ((cfg_index == pidc_pkg::REG_OUT_MIN) ||
                        (cfg_index == pidc_pkg::REG_OUT_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      out_min       <= '0;
      out_max       <= DATA_WIDTH'(pidc_pkg::OUT_MAX_RESET);
      mode          <= '0;
      sample_period <= pidc_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (pidc_pkg::cfg_reg_t'(cfg_index))
        pidc_pkg::REG_GAIN_P:     gain_p        <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_GAIN_I:     gain_i        <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_GAIN_D:     gain_d        <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_OUT_MIN:    out_min       <= cfg_data[DATA_WIDTH-1:0];
        pidc_pkg::REG_OUT_MAX:    out_max       <= cfg_data[DATA_WIDTH-1:0];
        pidc_pkg::REG_P_ON_MEAS:  mode.p_on_meas <= cfg_data[0];
        pidc_pkg::REG_REVERSE:    mode.reverse  <= cfg_data[0];
        pidc_pkg::REG_SAMPLE_PER: sample_period <= cfg_data[pidc_pkg::TICK_W-1:0];
        default:                  gain_p        <= gain_p;
      endcase
    end
  end

  // The state moves only with a tick; a pending re-clamp applies otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum  <= '0;
      clamp_pending <= 1'b0;
      last_measured <= '0;
      ticks         <= '1;
      auto_flag     <= 1'b0;
    end else begin
      clamp_pending <= limit_write;
      if (advance) begin
        integral_sum  <= integral_next;
        last_measured <= last_next;
        ticks         <= ticks_next;
        auto_flag     <= auto_next;
      end else if (clamp_pending) begin
        integral_sum  <= integral_hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_measured  <= measured;
      s1_target    <= target;
      s1_auto_mode <= auto_mode;
      s1_manual    <= manual_output;
    end
  end

  pidc_core #(
    .DATA_WIDTH(DATA_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_core (
    .measured(s1_measured),
    .target(s1_target),
    .auto_mode(s1_auto_mode),
    .manual_output(s1_manual),
    .gain_p(gain_p),
    .gain_i(gain_i),
    .gain_d(gain_d),
    .out_min(out_min),
    .out_max(out_max),
    .mode(mode),
    .sample_period(sample_period),
    .integral_sum(integral_sum),
    .clamp_pending(clamp_pending),
    .last_measured(last_measured),
    .ticks(ticks),
    .auto_flag(auto_flag),
    .integral_hold(integral_hold),
    .integral_next(integral_next),
    .last_next(last_next),
    .ticks_next(ticks_next),
    .auto_next(auto_next),
    .drive(drive_next),
    .computed(computed_next)
  );

  // Result register: filled by a moving tick, emptied by the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive    <= drive_next;
      computed <= computed_next;
      in_auto  <= auto_next;
    end
  end

endmodule
